// File: hw/rtl/periodic_timer_bank_scan_assert.svh
// Assertion macros used by the timer bank top-level file.
`ifndef PERIODIC_TIMER_BANK_SCAN_ASSERT_SVH
`define PERIODIC_TIMER_BANK_SCAN_ASSERT_SVH

`ifndef SYNTH

// Checks a property on every rising clock edge outside reset.
`define PTBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition implies another one on the next clock edge.
`define PTBS_ASSERT_NEXT(lbl, cond, nxt, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (nxt)) \
        else $error(msg);

`else

`define PTBS_ASSERT(lbl, prop, msg)
`define PTBS_ASSERT_NEXT(lbl, cond, nxt, msg)

`endif

`endif

// File: hw/rtl/ptbs_pkg.sv
package ptbs_pkg;

    // Bank geometry and field widths.
    localparam int SLOTS     = 16;
    localparam int IDX_BITS  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 32;
    localparam int WAIT_W    = 32;
    localparam logic [WAIT_W-1:0] MAX_WAIT_RST = WAIT_W'(2000000);

    // Input action codes.
    typedef enum logic [1:0] {
        ACT_SCAN   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_SET    = 2'd2,
        ACT_REMOVE = 2'd3
    } t_action;

    // Result kind codes.
    typedef enum logic [1:0] {
        KIND_FIRED  = 2'd0,
        KIND_DONE   = 2'd1,
        KIND_ACCEPT = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic finish;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic scan_end;
    } t_dp_stat;

endpackage

// File: hw/rtl/periodic_timer_bank_scan.sv
// Command (add, set period, removal): it is latched on acceptance, then checked, and its result
// is written to the output register; the next transaction can be accepted after that write.
// Scan: one slot per cycle through the single bank read port while the output register is free;
// each firing is a result of its own, and the closing wait result follows the last slot.
// A stalled consumer that holds the output register stalls commands and scans alike.
// Reset is synchronous and active low: all slots empty, no removals marked, max_wait 2000000.
`include "periodic_timer_bank_scan_assert.svh"

module periodic_timer_bank_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [ptbs_pkg::SLOT_W-1:0] i_slot,
    input  logic [ptbs_pkg::TIME_W-1:0] i_period,
    input  logic [ptbs_pkg::TIME_W-1:0] i_now,
    input  logic                        i_cfg_we,
    input  logic [ptbs_pkg::WAIT_W-1:0] i_cfg_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [1:0]                  o_kind,
    output logic [ptbs_pkg::SLOT_W-1:0] o_fired_slot,
    output logic [ptbs_pkg::WAIT_W-1:0] o_wait_res,
    output logic                        o_last
);
    import ptbs_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     is_scan;
    logic     out_done;

    assign is_scan = (i_action == ACT_SCAN);

    // Sequencer.
    ptbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_is_scan  (is_scan),
        .i_stat     (dp_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (dp_cmd)
    );

    // Timer bank, scan arithmetic and output register.
    ptbs_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_action     (i_action),
        .i_slot       (i_slot),
        .i_period     (i_period),
        .i_now        (i_now),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_fired_slot (o_fired_slot),
        .o_wait_res   (o_wait_res),
        .o_last       (o_last)
    );

    // A scan-done result is on the output.
    assign out_done = o_out_valid && (o_kind == KIND_DONE);

    // Only one datapath command is issued in any cycle.
    `PTBS_ASSERT(a_one_cmd, $onehot0(dp_cmd), "several datapath commands at once")
    // One transaction at a time: the block is busy right after an acceptance.
    `PTBS_ASSERT_NEXT(a_busy, i_in_valid && o_in_ready, !o_in_ready, "accepted while busy")
    // Only a fired result may be followed by further results of the same transaction.
    `PTBS_ASSERT(a_mid_fired, o_out_valid && !o_last |-> o_kind == KIND_FIRED, "not a firing")
    // A scan-done result is final and carries slot zero.
    `PTBS_ASSERT(a_done_form, out_done |-> o_last && o_fired_slot == '0, "bad scan-done result")

endmodule

// File: hw/rtl/ptbs_ctrl.sv
module ptbs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_is_scan,
    input  ptbs_pkg::t_dp_stat i_stat,
    output logic              o_in_ready,
    output ptbs_pkg::t_dp_cmd o_cmd
);
    import ptbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_is_scan ? S_SCAN : S_CMD;
                end
            end
            S_CMD: begin
                if (i_stat.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_stat.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_stat.scan_end) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/ptbs_dp.sv
module ptbs_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptbs_pkg::t_dp_cmd                  i_cmd,
    output ptbs_pkg::t_dp_stat                 o_stat,
    input  logic [1:0]                         i_action,
    input  logic [ptbs_pkg::SLOT_W-1:0]        i_slot,
    input  logic [ptbs_pkg::TIME_W-1:0]        i_period,
    input  logic [ptbs_pkg::TIME_W-1:0]        i_now,
    input  logic                               i_cfg_we,
    input  logic [ptbs_pkg::WAIT_W-1:0]        i_cfg_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [1:0]                         o_kind,
    output logic [ptbs_pkg::SLOT_W-1:0]        o_fired_slot,
    output logic [ptbs_pkg::WAIT_W-1:0]        o_wait_res,
    output logic                               o_last
);
    import ptbs_pkg::*;

    // Latched transaction.
    t_action             r_action;
    logic [SLOT_W-1:0]   r_slot;
    logic [TIME_W-1:0]   r_period;
    logic [TIME_W-1:0]   r_now;

    // Timer bank.
    logic [SLOTS-1:0]    r_live;
    logic [SLOTS-1:0]    r_pend;
    logic [TIME_W-1:0]   r_per   [SLOTS];
    logic [TIME_W-1:0]   r_start [SLOTS];

    // Scan state and configuration.
    logic [IDX_BITS-1:0] r_idx;
    logic [TIME_W-1:0]   r_least;
    logic [TIME_W-1:0]   n_least;
    logic [WAIT_W-1:0]   r_max_wait;

    // Output register.
    logic                r_out_valid;
    logic                n_out_valid;
    t_kind               r_kind;
    t_kind               n_kind;
    logic [SLOT_W-1:0]   r_fslot;
    logic [SLOT_W-1:0]   n_fslot;
    logic [WAIT_W-1:0]   r_wait;
    logic [WAIT_W-1:0]   n_wait;
    logic                r_last;
    logic                n_last;

    // Read side of the bank.
    logic [IDX_BITS-1:0] rd_idx;
    logic                rd_live;
    logic [TIME_W-1:0]   rd_per;
    logic [TIME_W-1:0]   rd_start;
    logic [TIME_W-1:0]   elapsed;
    logic [TIME_W-1:0]   rem;
    logic                fire;
    logic                slot_ok;
    logic                cmd_ok;
    logic [WAIT_W-1:0]   wait_val;

    // A scan walks the index counter; a command addresses its own slot.
    assign rd_idx   = (r_action == ACT_SCAN) ? r_idx : r_slot[IDX_BITS-1:0];
    assign rd_live  = r_live[rd_idx];
    assign rd_per   = r_per[rd_idx];
    assign rd_start = r_start[rd_idx];

    // Expiry test for the visited slot. After a firing the full period remains.
    assign elapsed = r_now - rd_start;
    assign fire    = rd_live && (elapsed > rd_per);
    assign rem     = fire ? rd_per : (rd_per - elapsed);

    // Command check.
    assign slot_ok = {1'b0, r_slot} < (SLOT_W + 1)'(SLOTS);
    always_comb begin
        unique case (r_action)
            ACT_ADD:    cmd_ok = slot_ok && !rd_live;
            ACT_SET:    cmd_ok = slot_ok && rd_live;
            ACT_REMOVE: cmd_ok = slot_ok && rd_live;
            default:    cmd_ok = 1'b0;
        endcase
    end

    assign wait_val = (WAIT_W'(r_least) < r_max_wait) ? WAIT_W'(r_least) : r_max_wait;

    // Running minimum of the remaining time over live slots.
    always_comb begin
        n_least = r_least;
        if (i_cmd.load) begin
            n_least = '1;
        end else if (i_cmd.step && rd_live && (rem < r_least)) begin
            n_least = rem;
        end
    end

    // Output register next values: a result loads it, a taken result frees it.
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        n_kind      = r_kind;
        n_fslot     = r_fslot;
        n_wait      = r_wait;
        n_last      = r_last;
        if (i_cmd.exec) begin
            n_out_valid = 1'b1;
            n_kind      = cmd_ok ? KIND_ACCEPT : KIND_REJECT;
            n_fslot     = r_slot;
            n_wait      = '0;
            n_last      = 1'b1;
        end else if (i_cmd.step && fire) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_FIRED;
            n_fslot     = SLOT_W'(r_idx);
            n_wait      = '0;
            n_last      = 1'b0;
        end else if (i_cmd.finish) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_DONE;
            n_fslot     = '0;
            n_wait      = wait_val;
            n_last      = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_least     <= '1;
            r_max_wait  <= MAX_WAIT_RST;
            r_live      <= '0;
            r_pend      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_least     <= n_least;
            if (i_cfg_we) begin
                r_max_wait <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.exec && cmd_ok) begin
                if (r_action == ACT_ADD) begin
                    r_live[rd_idx] <= 1'b1;
                    r_pend[rd_idx] <= 1'b0;
                end else if (r_action == ACT_REMOVE) begin
                    r_pend[rd_idx] <= 1'b1;
                end
            end
            // Removals take effect once the scan has finished.
            if (i_cmd.finish) begin
                r_live <= r_live & ~r_pend;
                r_pend <= '0;
            end
        end
    end

    // Payload registers and the timer values.
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_fslot <= n_fslot;
        r_wait  <= n_wait;
        r_last  <= n_last;
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_slot   <= i_slot;
            r_period <= i_period;
            r_now    <= i_now;
        end
        if (i_cmd.exec && cmd_ok) begin
            if (r_action == ACT_ADD) begin
                r_per[rd_idx]   <= r_period;
                r_start[rd_idx] <= r_now;
            end else if (r_action == ACT_SET) begin
                r_per[rd_idx] <= r_period;
            end
        end
        if (i_cmd.step && fire) begin
            r_start[rd_idx] <= r_now;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.scan_end = (r_idx == IDX_BITS'(SLOTS - 1));

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_fired_slot = r_fslot;
    assign o_wait_res   = r_wait;
    assign o_last       = r_last;

endmodule

// File: dv/tb_top.sv
module tb_top;
    import ptbs_pkg::*;

    // One command or scan as offered on the input channel.
    typedef struct packed {
        t_action     action;
        logic [3:0]  slot;
        logic [31:0] period;
        logic [31:0] now;
    } t_timer_cmd;

    // One result as produced on the output channel.
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  slot;
        logic [31:0] wait_res;
        logic        last;
    } t_timer_result;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 24;
    localparam int BACKPRESSURE_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_action = '0;
    logic [3:0]  i_slot = '0;
    logic [31:0] i_period = '0;
    logic [31:0] i_now = '0;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_kind;
    logic [3:0]  o_fired_slot;
    logic [31:0] o_wait_res;
    logic        o_last;

    // Predicted state of the timer bank.
    logic        bank_live[SLOTS];
    logic        bank_marked[SLOTS];
    logic [31:0] bank_period[SLOTS];
    logic [31:0] bank_start[SLOTS];
    logic [31:0] cfg_max_wait = MAX_WAIT_RST;

    // Occupancy as seen by the stimulus generator, ahead of the block.
    logic        gen_live[SLOTS];
    logic        gen_marked[SLOTS];
    logic [31:0] gen_now = '0;

    t_timer_cmd    timer_cmds_pending[$];
    t_timer_result timer_results_due[$];

    int unsigned cycle_no = 0;
    int unsigned errors = 0;
    int unsigned items_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned scans_done = 0;
    int unsigned expiries = 0;
    int unsigned rejects = 0;
    int unsigned cap_settings = 1;

    periodic_timer_bank_scan dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_slot       (i_slot),
        .i_period     (i_period),
        .i_now        (i_now),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_fired_slot (o_fired_slot),
        .o_wait_res   (o_wait_res),
        .o_last       (o_last)
    );

    // Free-running clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
    end

    // Mostly short gaps, with the occasional long one.
    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 19) == 0) begin
            return $urandom_range(20, 80);
        end
        return $urandom_range(0, 3);
    endfunction

    // Short periods so that timers fire often, plus the extreme values.
    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 11))
            0: return '1;
            1: return '0;
            2: return $urandom();
            3: return 32'hFFFF_FFFE;
            default: return $urandom_range(1, 400);
        endcase
    endfunction

    // Prefers a slot whose occupancy matches what the command needs to succeed.
    function automatic logic [3:0] pick_slot(input logic want_live);
        logic [3:0] s;
        s = 4'($urandom());
        for (int t = 0; t < 32; t++) begin
            if (gen_live[s] == want_live) begin
                return s;
            end
            s = 4'($urandom());
        end
        return s;
    endfunction

    // Applies one accepted transaction to the predicted bank and queues its results.
    task automatic advance_timer_bank(input t_timer_cmd cmd);
        logic [32:0]   least;
        logic [31:0]   elapsed;
        logic          accepted;
        t_timer_result res;
        res = '0;
        if (cmd.action == ACT_SCAN) begin
            least = '1;
            for (int i = 0; i < SLOTS; i++) begin
                if (bank_live[i]) begin
                    elapsed = cmd.now - bank_start[i];
                    if (elapsed > bank_period[i]) begin
                        res.kind = KIND_FIRED;
                        res.slot = 4'(i);
                        res.wait_res = '0;
                        res.last = 1'b0;
                        timer_results_due = {timer_results_due, res};
                        bank_start[i] = cmd.now;
                        elapsed = '0;
                        expiries++;
                    end
                    if ({1'b0, bank_period[i] - elapsed} < least) begin
                        least = {1'b0, bank_period[i] - elapsed};
                    end
                end
            end
            // Removals take effect only once the scan is complete.
            for (int i = 0; i < SLOTS; i++) begin
                if (bank_marked[i]) begin
                    bank_live[i] = 1'b0;
                end
                bank_marked[i] = 1'b0;
            end
            res.kind = KIND_DONE;
            res.slot = '0;
            res.wait_res = (least < {1'b0, cfg_max_wait}) ? least[31:0] : cfg_max_wait;
            res.last = 1'b1;
            timer_results_due = {timer_results_due, res};
            scans_done++;
        end else begin
            accepted = 1'b0;
            case (cmd.action)
                ACT_ADD: begin
                    if (!bank_live[cmd.slot]) begin
                        bank_live[cmd.slot] = 1'b1;
                        bank_period[cmd.slot] = cmd.period;
                        bank_start[cmd.slot] = cmd.now;
                        bank_marked[cmd.slot] = 1'b0;
                        accepted = 1'b1;
                    end
                end
                ACT_SET: begin
                    if (bank_live[cmd.slot]) begin
                        bank_period[cmd.slot] = cmd.period;
                        accepted = 1'b1;
                    end
                end
                default: begin
                    if (bank_live[cmd.slot]) begin
                        bank_marked[cmd.slot] = 1'b1;
                        accepted = 1'b1;
                    end
                end
            endcase
            if (!accepted) begin
                rejects++;
            end
            res.kind = accepted ? KIND_ACCEPT : KIND_REJECT;
            res.slot = cmd.slot;
            res.wait_res = '0;
            res.last = 1'b1;
            timer_results_due = {timer_results_due, res};
        end
    endtask

    task automatic queue_cmd(input t_action action, input logic [3:0] slot,
                             input logic [31:0] period, input logic [31:0] now);
        t_timer_cmd cmd;
        cmd.action = action;
        cmd.slot = slot;
        cmd.period = period;
        cmd.now = now;
        timer_cmds_pending = {timer_cmds_pending, cmd};
    endtask

    // Mostly well-formed traffic on a moving time base, with some noise mixed in.
    task automatic queue_random_cmds(input int count);
        t_timer_cmd  cmd;
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            cmd.period = pick_period();
            cmd.now = $urandom();
            cmd.slot = 4'($urandom());
            if (pick < 30) begin
                cmd.action = ACT_SCAN;
                if ($urandom_range(0, 24) == 0) begin
                    gen_now = $urandom();
                end else begin
                    gen_now = gen_now + $urandom_range(0, 150);
                end
                cmd.now = gen_now;
                for (int i = 0; i < SLOTS; i++) begin
                    if (gen_marked[i]) begin
                        gen_live[i] = 1'b0;
                    end
                    gen_marked[i] = 1'b0;
                end
            end else begin
                if (pick < 60) begin
                    cmd.action = ACT_ADD;
                end else if (pick < 80) begin
                    cmd.action = ACT_SET;
                end else begin
                    cmd.action = ACT_REMOVE;
                end
                if ($urandom_range(0, 6) != 0) begin
                    cmd.slot = pick_slot(cmd.action != ACT_ADD);
                end
                if (cmd.action == ACT_ADD) begin
                    if ($urandom_range(0, 9) != 0) begin
                        cmd.now = gen_now - $urandom_range(0, 60);
                    end
                    if (!gen_live[cmd.slot]) begin
                        gen_live[cmd.slot] = 1'b1;
                        gen_marked[cmd.slot] = 1'b0;
                    end
                end else if (cmd.action == ACT_REMOVE && gen_live[cmd.slot]) begin
                    gen_marked[cmd.slot] = 1'b1;
                end
            end
            timer_cmds_pending = {timer_cmds_pending, cmd};
        end
    endtask

    // Waits until every queued transaction has been sent and answered, then lets the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        while (timer_cmds_pending.size() != 0 || i_in_valid || timer_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_wait(input logic [31:0] value);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_max_wait = value;
        cap_settings++;
    endtask

    // Input driver: offers queued transactions and records each one as it is accepted.
    always @(posedge i_clk) begin : cmd_driver
        t_timer_cmd  cmd;
        int unsigned send_gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                cmd.action = t_action'(i_action);
                cmd.slot = i_slot;
                cmd.period = i_period;
                cmd.now = i_now;
                advance_timer_bank(cmd);
                items_accepted++;
            end
            if (i_in_valid && !o_in_ready) begin
                // Hold the offered transaction until it is taken.
            end else if (send_gap != 0) begin
                send_gap = send_gap - 1;
                i_in_valid <= 1'b0;
            end else if (timer_cmds_pending.size() != 0) begin
                cmd = timer_cmds_pending.pop_front();
                i_action <= cmd.action;
                i_slot <= cmd.slot;
                i_period <= cmd.period;
                i_now <= cmd.now;
                i_in_valid <= 1'b1;
                send_gap = (cycle_no[8:7] == 2'b00) ? 0 : pick_gap();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: checks each result against the oldest prediction and paces ready.
    always @(posedge i_clk) begin : result_monitor
        t_timer_result due;
        int unsigned   recv_gap;
        int unsigned   hold_left;
        logic          held_once;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
            held_once = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_checked++;
                if (timer_results_due.size() == 0) begin
                    $display("%0t: unexpected result: kind %0d slot %0d wait %0d last %0d",
                             $time, o_kind, o_fired_slot, o_wait_res, o_last);
                    errors++;
                end else begin
                    due = timer_results_due.pop_front();
                    if (o_kind !== due.kind) begin
                        $display("%0t: kind mismatch: expected %0d, actual %0d",
                                 $time, due.kind, o_kind);
                        errors++;
                    end
                    if (o_fired_slot !== due.slot) begin
                        $display("%0t: slot mismatch: expected %0d, actual %0d",
                                 $time, due.slot, o_fired_slot);
                        errors++;
                    end
                    if (o_wait_res !== due.wait_res) begin
                        $display("%0t: wait mismatch: expected %0d, actual %0d",
                                 $time, due.wait_res, o_wait_res);
                        errors++;
                    end
                    if (o_last !== due.last) begin
                        $display("%0t: last mismatch: expected %0d, actual %0d",
                                 $time, due.last, o_last);
                        errors++;
                    end
                end
                // Once in the run, refuse results for a long stretch so the block backs up.
                if (!held_once && results_checked == 60) begin
                    hold_left = BACKPRESSURE_CYCLES;
                    held_once = 1'b1;
                end
            end
            if (hold_left != 0) begin
                hold_left = hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (recv_gap != 0) begin
                recv_gap = recv_gap - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if (cycle_no[9:8] != 2'b01 && $urandom_range(0, 2) == 0) begin
                    recv_gap = pick_gap();
                end
            end
        end
    end

    // Watchdog: ends the run if no transaction of any kind completes for too long.
    always @(posedge i_clk) begin : stall_watchdog
        int unsigned quiet_cycles;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, timer_results_due.size());
                $display("periodic_timer_bank_scan regression: fail");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            bank_live[i] = 1'b0;
            bank_marked[i] = 1'b0;
            bank_period[i] = '0;
            bank_start[i] = '0;
            gen_live[i] = 1'b0;
            gen_marked[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, under the reset value of the wait cap.
        queue_cmd(ACT_SCAN, 4'd0, 32'd0, 32'd0);                 // empty bank reports the cap
        queue_cmd(ACT_SET, 4'd3, 32'd7, 32'd0);                  // set on an empty slot
        queue_cmd(ACT_REMOVE, 4'd5, 32'd0, 32'd0);               // removal on an empty slot
        queue_cmd(ACT_ADD, 4'd0, 32'd10, 32'd100);
        queue_cmd(ACT_ADD, 4'd0, 32'd20, 32'd0);                 // slot already occupied
        queue_cmd(ACT_ADD, 4'd15, 32'hFFFF_FFFF, 32'd0);         // never fires
        queue_cmd(ACT_ADD, 4'd7, 32'd0, 32'hFFFF_FFF0);
        queue_cmd(ACT_SCAN, 4'd9, 32'd0, 32'd110);               // elapsed equal to period
        queue_cmd(ACT_SCAN, 4'd0, 32'd0, 32'd111);               // elapsed just above period
        queue_cmd(ACT_SET, 4'd0, 32'hFFFF_FFFE, 32'd0);
        queue_cmd(ACT_REMOVE, 4'd7, 32'd0, 32'd0);
        queue_cmd(ACT_REMOVE, 4'd7, 32'd0, 32'd0);               // marked twice
        queue_cmd(ACT_ADD, 4'd7, 32'd3, 32'd0);                  // still live until the scan
        queue_cmd(ACT_SCAN, 4'd0, 32'd0, 32'hFFFF_FFFF);
        queue_cmd(ACT_SET, 4'd7, 32'd3, 32'd0);                  // cleared by that scan
        queue_cmd(ACT_ADD, 4'd7, 32'd5, 32'hFFFF_FFFE);
        queue_cmd(ACT_SCAN, 4'd0, 32'd0, 32'd3);                 // elapsed wraps through zero
        queue_cmd(ACT_SCAN, 4'd0, 32'd0, 32'd4);
        queue_cmd(ACT_ADD, 4'd10, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_cmd(ACT_REMOVE, 4'd15, 32'd0, 32'd0);
        queue_cmd(ACT_REMOVE, 4'd0, 32'd0, 32'd0);
        queue_cmd(ACT_REMOVE, 4'd7, 32'd0, 32'd0);
        queue_cmd(ACT_REMOVE, 4'd10, 32'd0, 32'd0);
        queue_cmd(ACT_SCAN, 4'd0, 32'd0, 32'h5555_5555);
        queue_cmd(ACT_SCAN, 4'd15, 32'hFFFF_FFFF, 32'hAAAA_AAAA);

        // Random part across several wait caps, the extremes among them.
        write_max_wait(32'd0);
        gen_now = 32'd1000;
        queue_random_cmds(86);
        write_max_wait(32'hFFFF_FFFF);
        gen_now = 32'hFFFF_F000;
        queue_random_cmds(86);
        write_max_wait(32'd100);
        queue_random_cmds(86);
        write_max_wait($urandom_range(1, 2000));
        queue_random_cmds(87);

        wait_drained();
        $display("Ran %0d transactions (%0d scans, %0d rejected commands) under %0d wait caps.",
                 items_accepted, scans_done, rejects, cap_settings);
        $display("Checked %0d results, %0d of them timer expiries, with %0d mismatches.",
                 results_checked, expiries, errors);
        if (errors == 0) begin
            $display("periodic_timer_bank_scan regression: pass");
        end else begin
            $display("periodic_timer_bank_scan regression: fail");
        end
        $finish;
    end

endmodule

// File: periodic_timer_bank_scan.f
+incdir+hw/rtl
hw/rtl/ptbs_pkg.sv
hw/rtl/ptbs_ctrl.sv
hw/rtl/ptbs_dp.sv
hw/rtl/periodic_timer_bank_scan.sv
dv/tb_top.sv
